// File: hdl/thsk_pkg.sv
// Shared types and constants of the tap/hold shortcut key block.
// No dependencies; imported by every module of the block.
`default_nettype none

package thsk_pkg;

  localparam int unsigned MAX_SLOTS    = 4;
  localparam int unsigned NUM_SLOTS_DEF = 4;
  localparam int unsigned SLOT_IDX_W   = $clog2(MAX_SLOTS);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TERM = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNDO      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CUT       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_COPY      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_PASTE     = 3'd4;

  localparam logic [2:0] CLS_TOGGLE = 3'd4;

  localparam logic [7:0] KC_LCTL = 8'd224;
  localparam logic [7:0] KC_LGUI = 8'd227;
  localparam logic [7:0] KC_Z    = 8'd29;
  localparam logic [7:0] KC_X    = 8'd27;
  localparam logic [7:0] KC_C    = 8'd6;
  localparam logic [7:0] KC_V    = 8'd25;

  localparam logic [15:0] HOLD_TERM_RESET = 16'd200;
  localparam logic [MAX_SLOTS-1:0][7:0] CODE_RESET = {KC_V, KC_C, KC_X, KC_Z};

  typedef enum logic [1:0] {
    ACT_MOD_DOWN = 2'd0,
    ACT_TAP      = 2'd1,
    ACT_MOD_UP   = 2'd2,
    ACT_FORWARD  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_TAP  = 2'd1,
    TAIL_FWD  = 2'd2
  } tail_e;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  key_class;
    logic        pressed;
    logic [15:0] now_ms;
  } in_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] key_code;
    logic       last;
  } out_t;

  // One queued job: either a hold-fire sweep, or a tap sweep, a tail, or both.
  typedef struct packed {
    logic                  fire;
    logic                  mod_gui;
    logic [MAX_SLOTS-1:0]  mask;
    tail_e                 tail;
    logic [SLOT_IDX_W-1:0] slot;
  } job_t;

  typedef struct packed {
    logic [MAX_SLOTS-1:0] pending;
    logic [MAX_SLOTS-1:0] fired;
  } slot_status_t;

endpackage

`default_nettype wire

// File: hdl/thsk_queue.sv
// Short job queue between the front and back parts.
// Depends on thsk_pkg (job_t, QUEUE_DEPTH).
`default_nettype none

module thsk_queue import thsk_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  input  wire logic pop_i,
  output job_t      pop_data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_FULL);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/thsk_front.sv
// Front part: accepts key events and scan ticks, keeps per-slot tap/hold
// state and turns each transaction that has results to play into a job. Depends on thsk_pkg.
`default_nettype none

module thsk_front import thsk_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_i,
  input  wire logic [15:0] hold_term_i,
  input  wire logic        queue_full_i,
  output logic             push_o,
  output job_t             job_o,
  output slot_status_t     status_o
);

  localparam int unsigned ACTIVE = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int unsigned SLOT_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [2:0]  ACTIVE_CLS = 3'(ACTIVE);

  logic [ACTIVE-1:0] pending_q, pending_d;
  logic [ACTIVE-1:0] fired_q, fired_d;
  logic              mac_q, mac_d;
  logic [15:0]       stamp_q [ACTIVE];

  logic [ACTIVE-1:0] live;
  logic [ACTIVE-1:0] due;
  logic [15:0]       elapsed [ACTIVE];
  logic              accept;
  logic              is_slot;
  logic              stamp_we;
  logic [SLOT_W-1:0] slot;
  job_t              job;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign is_slot    = (in_i.key_class < ACTIVE_CLS);
  assign slot       = in_i.key_class[SLOT_W-1:0];
  assign live       = pending_q & ~fired_q;

  always_comb begin
    for (int i = 0; i < ACTIVE; i++) begin
      elapsed[i] = in_i.now_ms - stamp_q[i];
      due[i]     = live[i] && (elapsed[i] > hold_term_i);
    end
  end

  always_comb begin
    pending_d = pending_q;
    fired_d   = fired_q;
    mac_d     = mac_q;
    stamp_we  = 1'b0;
    job         = '0;
    job.mod_gui = mac_q;
    job.tail    = TAIL_NONE;
    if (in_i.req_type) begin
      job.fire  = 1'b1;
      job.mask  = MAX_SLOTS'(due);
      pending_d = pending_q & ~due;
      fired_d   = fired_q | due;
    end else begin
      if (in_i.pressed) begin
        job.mask  = MAX_SLOTS'(live);
        pending_d = pending_q & ~live;
      end
      if (in_i.key_class == CLS_TOGGLE) begin
        if (in_i.pressed) begin
          mac_d = !mac_q;
        end
      end else if (is_slot) begin
        if (in_i.pressed) begin
          pending_d[slot] = 1'b1;
          fired_d[slot]   = 1'b0;
          stamp_we        = 1'b1;
        end else if (fired_q[slot]) begin
          fired_d[slot] = 1'b0;
        end else if (pending_q[slot]) begin
          pending_d[slot] = 1'b0;
          job.tail        = TAIL_TAP;
          job.slot        = SLOT_IDX_W'(slot);
        end
      end else begin
        job.tail = TAIL_FWD;
      end
    end
  end

  assign push_o = accept && ((job.mask != '0) || (job.tail != TAIL_NONE));
  assign job_o  = job;

  assign status_o.pending = MAX_SLOTS'(pending_q);
  assign status_o.fired   = MAX_SLOTS'(fired_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      fired_q   <= '0;
      mac_q     <= 1'b0;
    end else if (accept) begin
      pending_q <= pending_d;
      fired_q   <= fired_d;
      mac_q     <= mac_d;
    end
  end

  // stamps are only read while the slot is pending
  always_ff @(posedge clk_i) begin
    if (accept && stamp_we) begin
      stamp_q[slot] <= in_i.now_ms;
    end
  end

endmodule

`default_nettype wire

// File: hdl/thsk_back.sv
// Back part: takes jobs from the queue and plays them out as result
// transactions, one per cycle while out_ready_i is high, through an output register. Depends on thsk_pkg.
`default_nettype none

module thsk_back import thsk_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  input  wire job_t                       job_i,
  output logic                            pop_o,
  input  wire logic [MAX_SLOTS-1:0][7:0]  codes_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output out_t                            out_o
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_FIRE_DN  = 6'b000010,
    ST_FIRE_TAP = 6'b000100,
    ST_FIRE_UP  = 6'b001000,
    ST_RESOLVE  = 6'b010000,
    ST_TAIL     = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  job_t                 job_q, job_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  logic                 out_free;
  logic [SLOT_IDX_W-1:0] low_idx;
  logic [MAX_SLOTS-1:0] low_bit;
  logic [MAX_SLOTS-1:0] rest;
  logic [7:0]           mod_code;

  assign out_free = !out_valid_q || out_ready_i;
  assign low_bit  = job_q.mask & (~job_q.mask + 1'b1);
  assign rest     = job_q.mask & ~low_bit;
  assign mod_code = job_q.mod_gui ? KC_LGUI : KC_LCTL;

  always_comb begin
    low_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (job_q.mask[i]) begin
        low_idx = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          if (job_i.fire) begin
            state_d = ST_FIRE_DN;
          end else if (job_i.mask != '0) begin
            state_d = ST_RESOLVE;
          end else begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_FIRE_DN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{action: ACT_MOD_DOWN, key_code: mod_code, last: 1'b0};
          state_d     = ST_FIRE_TAP;
        end
      end
      ST_FIRE_TAP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{action: ACT_TAP, key_code: codes_i[low_idx], last: 1'b0};
          state_d     = ST_FIRE_UP;
        end
      end
      ST_FIRE_UP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{action: ACT_MOD_UP, key_code: mod_code, last: (rest == '0)};
          job_d.mask  = rest;
          state_d     = (rest != '0) ? ST_FIRE_DN : ST_IDLE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{action: ACT_TAP, key_code: codes_i[low_idx],
                          last: (rest == '0) && (job_q.tail == TAIL_NONE)};
          job_d.mask  = rest;
          if (rest != '0) begin
            state_d = ST_RESOLVE;
          end else if (job_q.tail != TAIL_NONE) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (job_q.tail == TAIL_TAP) begin
            out_d = '{action: ACT_TAP, key_code: codes_i[job_q.slot], last: 1'b1};
          end else begin
            out_d = '{action: ACT_FORWARD, key_code: 8'd0, last: 1'b1};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// File: hdl/tap_hold_shortcut_keys.sv
// Path: an accepted transaction passes the job queue, the back part's job register and its output register.
// Throughput: one result per cycle within a transaction while out_ready_i is high; the back part
// plays out one job at a time, up to 12 results for a tick that fires all four slots.
// The front takes a new transaction whenever the 2-entry job queue has room.
// Reset: slot flags, mode and queue clear at once; config registers return to defaults.
// Top level: config registers, front, job queue and back. Depends on thsk_pkg.
`default_nettype none

module tap_hold_shortcut_keys import thsk_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [15:0]                hold_term_q;
  logic [MAX_SLOTS-1:0][7:0]  code_q;

  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_empty;
  job_t         push_job;
  job_t         pop_job;
  slot_status_t slot_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_term_q <= HOLD_TERM_RESET;
      code_q      <= CODE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i) inside
        CFG_HOLD_TERM: hold_term_q <= cfg_wdata_i[15:0];
        CFG_UNDO, CFG_CUT, CFG_COPY, CFG_PASTE: begin
          code_q[SLOT_IDX_W'(cfg_addr_i - CFG_UNDO)] <= cfg_wdata_i[7:0];
        end
        default: ;
      endcase
    end
  end

  thsk_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .hold_term_i  (hold_term_q),
    .queue_full_i (q_full),
    .push_o       (push),
    .job_o        (push_job),
    .status_o     (slot_status)
  );

  thsk_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  thsk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .codes_i     (code_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("job queue read while empty");

  a_pend_fired_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_status.pending & slot_status.fired) == '0)
    else $error("slot both pending and fired");

  a_tick_no_new_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.req_type)
      |=> (slot_status.pending & ~$past(slot_status.pending)) == '0)
    else $error("scan tick set a pending slot");
`endif

endmodule

`default_nettype wire
